[rtl/core/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg: shared definitions for the Shell sort engine
// Gap sequence codes, register map constants and the fixed gap tables.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Width of one stored element and of the move counter.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MOVES_W = 16;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_GAP_SEQUENCE = 1'b0;

  // Gap sequence selector codes. The unused code behaves as powers of two.
  typedef logic [1:0] gap_sel_t;
  localparam gap_sel_t GAP_POW2   = 2'd0;
  localparam gap_sel_t GAP_KNUTH  = 2'd1;
  localparam gap_sel_t GAP_CIURA  = 2'd2;
  localparam gap_sel_t GAP_UNUSED = 2'd3;

  // Upper bound on the number of gap table entries that is ever consulted.
  localparam int unsigned GAP_TABLE_DEPTH = 30;

  typedef logic [21:0] gap_t;
  typedef logic [4:0]  gap_pos_t;

  localparam gap_t KNUTH_GAPS [0:13] = '{
    22'd1, 22'd4, 22'd13, 22'd40, 22'd121, 22'd364, 22'd1093, 22'd3280,
    22'd9841, 22'd29524, 22'd88573, 22'd265720, 22'd797161, 22'd2391484
  };

  localparam gap_t CIURA_GAPS [0:16] = '{
    22'd1, 22'd4, 22'd10, 22'd23, 22'd57, 22'd132, 22'd301, 22'd701, 22'd1577,
    22'd3548, 22'd7983, 22'd17961, 22'd40412, 22'd90927, 22'd204585,
    22'd460316, 22'd1035711
  };

  // Number of usable entries in the selected table.
  function automatic gap_pos_t gap_count(input gap_sel_t sel);
    int unsigned len;
    case (sel)
      GAP_KNUTH: len = 14;
      GAP_CIURA: len = 17;
      default:   len = 21;
    endcase
    if (len > GAP_TABLE_DEPTH) begin
      len = GAP_TABLE_DEPTH;
    end
    return gap_pos_t'(len);
  endfunction

  // Gap at one position of the selected table, zero past its end.
  function automatic gap_t gap_value(input gap_sel_t sel, input gap_pos_t pos);
    gap_t gap;
    gap = '0;
    if (pos < gap_count(sel)) begin
      case (sel)
        GAP_KNUTH: gap = KNUTH_GAPS[pos[3:0]];
        GAP_CIURA: gap = CIURA_GAPS[pos];
        default:   gap = gap_t'(1) << pos;
      endcase
    end
    return gap;
  endfunction

endpackage

[rtl/core/shell_sort_engine_top.sv]
// ----------------------------------------------------------------------------
// shell_sort_engine_top: streaming Shell sort engine
// Collects a data set of signed 32-bit elements, sorts it with Shell sort
// over a selectable gap table and streams it back in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake          | Payload
//  ----------+-----------+--------------------+-------------------------------
//  s_axis    | in        | tvalid / tready    | tdata[31:0] value, tlast last_in
//  m_axis    | out       | tvalid / tready    | tdata[31:0] sorted_value,
//            |           |                    | tdata[47:32] move_count,
//            |           |                    | tlast last_out
//  apb       | in        | psel/penable/pready| register 0 gap_sequence
//
// Loading takes items back to back. Once the closing item is in, the engine
// first scans the gap table (one entry per cycle), then runs the gapped
// insertion passes on a single compare-and-shift datapath that shares the
// element memory's one read and one write port: each key is read, larger
// neighbors one gap below are shifted up and the key is written. Results are
// read, then loaded into the output register one at a time; a stall on m_axis
// simply holds the engine in place. s_axis_tready is low from the closing
// item until the last result has been loaded into the output register.
// After reset the engine is empty and ready; the element memory is not
// cleared, since only entries that were written in the current set are read.
//
module shell_sort_engine_top #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sse_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] value
  input  logic                           s_axis_tlast,   // last_in

  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sse_pkg::DATA_W+sse_pkg::MOVES_W-1:0] m_axis_tdata,
                                         // [31:0] sorted_value, [47:32] move_count
  output logic                           m_axis_tlast,   // last_out

  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sse_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sse_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sse_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import sse_pkg::*;

  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ELEMENTS);
  localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

  // Sequencer states.
  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_SEARCH   = 3'd1;
  localparam logic [2:0] ST_KEY_RD   = 3'd2;
  localparam logic [2:0] ST_KEY_WAIT = 3'd3;
  localparam logic [2:0] ST_CMP      = 3'd4;
  localparam logic [2:0] ST_PLACE    = 3'd5;
  localparam logic [2:0] ST_OUT_RD   = 3'd6;
  localparam logic [2:0] ST_OUT_LD   = 3'd7;

  logic [2:0]          state_q, state_d;
  gap_sel_t            gap_sel_q, gap_sel_d;
  logic [CW-1:0]       count_q, count_d;
  logic [MOVES_W-1:0]  moves_q, moves_d;
  gap_pos_t            pos_q, pos_d;
  logic [DATA_W-1:0]   key_q, key_d;
  logic [IW-1:0]       gap_q, gap_d;
  logic [IW-1:0]       i_q, i_d;
  logic [IW-1:0]       j_q, j_d;
  logic [IW-1:0]       k_q, k_d;

  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_value_q, out_value_d;
  logic [MOVES_W-1:0]  out_moves_q, out_moves_d;
  logic                out_last_q, out_last_d;

  // Element memory: one write and one registered read per cycle.
  logic [DATA_W-1:0]   store_mem [MAX_ELEMENTS];
  logic [DATA_W-1:0]   rdata_q;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic                in_accept;
  logic                out_free;
  logic                cfg_write;
  logic [CW-1:0]       count_inc;
  logic [IW-1:0]       j_next;
  logic [IW-1:0]       prev_gap;
  logic                more_keys;
  logic                key_done;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign count_inc = count_q + CW'(1);
  assign j_next    = j_q - gap_q;
  assign prev_gap  = IW'(gap_value(gap_sel_q, pos_q - gap_pos_t'(1)));
  assign more_keys = (CW'(i_q) + CW'(1)) < count_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    moves_d     = moves_q;
    pos_d       = pos_q;
    key_d       = key_q;
    gap_d       = gap_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_value_d = out_value_q;
    out_moves_d = out_moves_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = j_q;
    mem_wdata   = key_q;
    mem_re      = 1'b0;
    mem_raddr   = j_next;
    key_done    = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IW-1:0];
          mem_wdata = s_axis_tdata;
          count_d   = count_inc;
          if (s_axis_tlast || (count_inc == COUNT_FULL)) begin
            pos_d   = '0;
            moves_d = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // Walk up to the first gap that is not below the element count.
        if ((pos_q < gap_count(gap_sel_q)) &&
            (gap_value(gap_sel_q, pos_q) < gap_t'(count_q))) begin
          pos_d = pos_q + gap_pos_t'(1);
        end else if (pos_q == '0) begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          pos_d   = pos_q - gap_pos_t'(1);
          gap_d   = prev_gap;
          i_d     = prev_gap;
          state_d = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q;
        j_d       = i_q;
        state_d   = ST_KEY_WAIT;
      end
      ST_KEY_WAIT: begin
        key_d     = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = j_next;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if ($signed(rdata_q) > $signed(key_q)) begin
          // Shift the larger neighbor up by one gap.
          mem_wdata = rdata_q;
          j_d       = j_next;
          if (moves_q != MOVES_MAX) begin
            moves_d = moves_q + MOVES_W'(1);
          end
          if (j_next >= gap_q) begin
            mem_re    = 1'b1;
            mem_raddr = j_next - gap_q;
          end else begin
            state_d = ST_PLACE;
          end
        end else begin
          key_done = 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we   = 1'b1;
        key_done = 1'b1;
      end
      ST_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rdata_q;
          out_moves_d = moves_q;
          out_last_d  = (CW'(k_q) + CW'(1)) == count_q;
          k_d         = k_q + IW'(1);
          if (out_last_d) begin
            count_d = '0;
            moves_d = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // The key is in place: take the next key of this gap, or the next gap.
    if (key_done) begin
      if (more_keys) begin
        i_d     = i_q + IW'(1);
        state_d = ST_KEY_RD;
      end else if (pos_q == '0) begin
        k_d     = '0;
        state_d = ST_OUT_RD;
      end else begin
        pos_d   = pos_q - gap_pos_t'(1);
        gap_d   = prev_gap;
        i_d     = prev_gap;
        state_d = ST_KEY_RD;
      end
    end
  end

  // Gap sequence register; the unused code is stored as powers of two.
  always_comb begin
    gap_sel_d = gap_sel_q;
    if (cfg_write && (paddr[2] == REG_GAP_SEQUENCE)) begin
      gap_sel_d = (pwdata[1:0] == GAP_UNUSED) ? GAP_POW2 : gap_sel_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      gap_sel_q   <= GAP_POW2;
      count_q     <= '0;
      moves_q     <= '0;
      pos_q       <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gap_sel_q   <= gap_sel_d;
      count_q     <= count_d;
      moves_q     <= moves_d;
      pos_q       <= pos_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q       <= gap_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    out_value_q <= out_value_d;
    out_moves_q <= out_moves_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_moves_q, out_value_q};
  assign m_axis_tlast  = out_last_q;
  assign pready        = 1'b1;
  assign prdata        = {{(APB_DATA_W-2){1'b0}},
                          (paddr[2] == REG_GAP_SEQUENCE) ? gap_sel_q : GAP_POW2};

  // The element count never runs past the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_FULL)
    else $error("element count exceeds store depth");

  // A neighbor compare always has a neighbor one gap below.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (j_q >= gap_q) && (gap_q != '0))
    else $error("compare step without a valid neighbor");

  // Results are only emitted from entries of the current data set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT_LD) |-> (CW'(k_q) < count_q))
    else $error("emission index beyond element count");

  // Outside loading, the memory is written only by the insertion steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !mem_we || (state_q == ST_CMP) || (state_q == ST_PLACE))
    else $error("memory write outside load and insertion");

endmodule

[test/shell_sort_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// shell_sort_engine_top_tb: self-checking bench for the Shell sort engine
// Streams data sets of signed elements into the engine under every gap table
// setting and compares each sorted item, its last flag and its move count
// against a behavioral Shell sort kept in the bench. The run mixes directed
// sets, random sets, full-store sets and random idling on both streams.
// ----------------------------------------------------------------------------
module shell_sort_engine_top_tb;
  import sse_pkg::*;

  localparam int unsigned SET_CAPACITY  = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned NUM_DIRECTED  = 20;

  localparam logic [APB_ADDR_W-1:0] GAP_SEQ_ADDR = APB_ADDR_W'(4 * REG_GAP_SEQUENCE);

  // One sorted item as it should leave the engine.
  typedef struct packed {
    logic [DATA_W-1:0]  value;
    logic               tail;
    logic [MOVES_W-1:0] moves;
  } sorted_elem_t;

  // One directed input item. A row marked single is a one-element data set,
  // so its result is known at a glance: the value itself, last, zero moves.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              closes;
    logic              single;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Single-element sets at the extremes and at zero.
    '{32'h7FFF_FFFF, 1'b1, 1'b1},
    '{32'h8000_0000, 1'b1, 1'b1},
    '{32'h0000_0000, 1'b1, 1'b1},
    // Two elements, largest first: one shift on the final pass.
    '{32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0},
    // Equal keys mixed with a negative one.
    '{32'h0000_0005, 1'b0, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0},
    '{32'h0000_0005, 1'b1, 1'b0},
    // Eight elements in descending signed order, alternating bit patterns.
    '{32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0},
    '{32'h8000_0001, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0},
    // All keys equal: nothing may move.
    '{32'hFFFF_FFFF, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0}
  };

  // Block inputs, all known from time zero.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [DATA_W-1:0]           s_axis_tdata  = '0;   // [31:0] value
  logic                        s_axis_tlast  = 1'b0; // last_in

  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [DATA_W+MOVES_W-1:0]   m_axis_tdata;         // [31:0] sorted_value, [47:32] move_count
  logic                        m_axis_tlast;         // last_out

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]       paddr   = '0;
  logic [APB_DATA_W-1:0]       pwdata  = '0;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;

  // Bench state: the set being collected, the sorted items still owed by the
  // engine, and the gap table currently selected.
  logic [DATA_W-1:0] pending_set [$];
  sorted_elem_t      sorted_q [$];
  gap_sel_t          active_gap = GAP_POW2;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold_go   = 1'b0;
  bit rx_hold      = 1'b0;

  int fail_count   = 0;
  int items_sent   = 0;
  int sets_closed  = 0;
  int results_seen = 0;
  int cycle_count  = 0;

  shell_sort_engine_top #(
    .MAX_ELEMENTS (SET_CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sorting predictor
  // --------------------------------------------------------------------------

  // Gap at one table position. A set never exceeds 64 elements, so entries
  // past the first one at or above 64 can never be selected and are left out.
  function automatic int gap_step(gap_sel_t sel, int pos);
    int step;
    case (sel)
      GAP_KNUTH: begin
        case (pos)
          0: step = 1;
          1: step = 4;
          2: step = 13;
          3: step = 40;
          default: step = 121;
        endcase
      end
      GAP_CIURA: begin
        case (pos)
          0: step = 1;
          1: step = 4;
          2: step = 10;
          3: step = 23;
          4: step = 57;
          default: step = 132;
        endcase
      end
      default: step = 1 << pos;
    endcase
    return step;
  endfunction

  // Shell sort of the collected set; queues one sorted item per element.
  function automatic void sort_pending_set();
    logic signed [DATA_W-1:0] arr [SET_CAPACITY];
    logic signed [DATA_W-1:0] key;
    sorted_elem_t             elem;
    int n;
    int pos;
    int h;
    int i;
    int j;
    int shifts;
    n = pending_set.size();
    for (i = 0; i < n; i++) begin
      arr[i] = pending_set[i];
    end
    // Start below the first gap that is not smaller than the element count.
    pos = 0;
    while (gap_step(active_gap, pos) < n) begin
      pos++;
    end
    shifts = 0;
    while (pos > 0) begin
      pos--;
      h = gap_step(active_gap, pos);
      // Gapped insertion over every offset chain at once.
      for (i = h; i < n; i++) begin
        key = arr[i];
        j = i;
        while (j >= h && arr[j - h] > key) begin
          arr[j] = arr[j - h];
          j -= h;
          if (shifts < 65535) begin
            shifts++;
          end
        end
        arr[j] = key;
      end
    end
    for (i = 0; i < n; i++) begin
      elem.value = arr[i];
      elem.tail  = (i == n - 1);
      elem.moves = MOVES_W'(shifts);
      sorted_q.push_back(elem);
    end
    pending_set.delete();
    sets_closed++;
  endfunction

  // Takes one accepted element. A full store closes the set on its own.
  function automatic void absorb_element(logic [DATA_W-1:0] value, logic closes);
    logic ends_set;
    ends_set = closes;
    if (pending_set.size() < SET_CAPACITY) begin
      pending_set.push_back(value);
    end
    if (pending_set.size() >= SET_CAPACITY) begin
      ends_set = 1'b1;
    end
    if (ends_set) begin
      sort_pending_set();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    fail_count++;
    $display("[%0t] mismatch at result %0d: %s got %h expected %h",
             $time, results_seen, what, got, want);
  endtask

  task automatic check_sorted_item(logic [DATA_W+MOVES_W-1:0] data, logic tail);
    sorted_elem_t want;
    results_seen++;
    if (sorted_q.size() == 0) begin
      report_mismatch("unexpected item, sorted_value", data[DATA_W-1:0], '0);
      return;
    end
    want = sorted_q.pop_front();
    if (data[DATA_W-1:0] !== want.value) begin
      report_mismatch("sorted_value", data[DATA_W-1:0], want.value);
    end
    if (data[DATA_W+MOVES_W-1:DATA_W] !== want.moves) begin
      report_mismatch("move_count", DATA_W'(data[DATA_W+MOVES_W-1:DATA_W]),
                      DATA_W'(want.moves));
    end
    if (tail !== want.tail) begin
      report_mismatch("last_out", DATA_W'(tail), DATA_W'(want.tail));
    end
  endtask

  // Output side: checks every accepted item and draws the next ready value.
  // The long hold forces ready low regardless of the stall percentage.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_sorted_item(m_axis_tdata, m_axis_tlast);
      end
      m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // One long receiver hold, counted here, while the sender keeps offering
  // items so that the engine backs up and stalls its input.
  initial begin : long_receiver_hold
    wait (rx_hold_go);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shell_sort_engine_top_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one element and returns at the edge that accepts it. Valid stays
  // high afterwards so that back-to-back items need no extra edge.
  task automatic send_element(logic [DATA_W-1:0] value, logic closes);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= closes;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sorted_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_write_gap(gap_sel_t sel);
    logic [APB_DATA_W-1:0] data;
    // Upper bits are noise; only the two low bits select the table.
    data      = $urandom();
    data[1:0] = sel;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAP_SEQ_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    active_gap = (sel == GAP_UNUSED) ? GAP_POW2 : sel;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_gap(output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= GAP_SEQ_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random element: full range, a narrow band that makes duplicates likely,
  // or one of the boundary patterns.
  function automatic logic [DATA_W-1:0] random_element();
    logic [DATA_W-1:0] value;
    case ($urandom_range(0, 3))
      0, 1: value = $urandom();
      2: value = DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
      default: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h0000_0000;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return value;
  endfunction

  // A set of the given size; without the closing flag only a full store ends it.
  task automatic send_random_set(int size, logic closes);
    logic [DATA_W-1:0] value;
    logic              ends_here;
    int k;
    for (k = 0; k < size; k++) begin
      value     = random_element();
      ends_here = (k == size - 1) && closes;
      send_element(value, ends_here);
      absorb_element(value, ends_here);
    end
  endtask

  // One phase: select a gap table while idle, set the idling mix, then run a
  // leading set (if any) followed by random sets until the item count is met.
  task automatic run_phase(gap_sel_t sel, int tx_pct, int rx_pct, int item_goal,
                           int lead_size, logic lead_closes, bit long_hold,
                           bit mid_pause);
    logic [APB_DATA_W-1:0] rd;
    int sent;
    int size;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write_gap(sel);
    if (sel != GAP_UNUSED) begin
      apb_read_gap(rd);
      if (rd[1:0] !== sel) begin
        report_mismatch("gap_sequence readback", rd, DATA_W'(sel));
      end
    end
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (long_hold) begin
      rx_hold_go = 1'b1;
    end
    sent = 0;
    if (lead_size > 0) begin
      send_random_set(lead_size, lead_closes);
      sent += lead_size;
    end
    if (mid_pause) begin
      // Hold the sender until the engine has emitted everything it owes.
      size = $urandom_range(2, 9);
      send_random_set(size, 1'b1);
      sent += size;
      wait_for_results();
    end
    while (sent < item_goal) begin
      size = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(size, 1'b1);
      sent += size;
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [APB_DATA_W-1:0] rd;
    stim_row_t             row;
    sorted_elem_t          single_result;
    int r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The selector must come out of reset as powers of two.
    apb_read_gap(rd);
    if (rd[1:0] !== GAP_POW2) begin
      report_mismatch("gap_sequence after reset", rd, DATA_W'(GAP_POW2));
    end

    // Directed sets under the reset gap table, no idling on either side.
    for (r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      send_element(row.value, row.closes);
      if (row.single) begin
        single_result.value = row.value;
        single_result.tail  = 1'b1;
        single_result.moves = '0;
        sorted_q.push_back(single_result);
        sets_closed++;
      end else begin
        absorb_element(row.value, row.closes);
      end
    end
    wait_for_results();

    // Knuth gaps; a 64-element set with no last flag closes on the full store.
    run_phase(GAP_KNUTH, 0, 0, 70, SET_CAPACITY, 1'b0, 1'b0, 1'b0);
    // Ciura gaps with a sparse sender; a full set that also carries last.
    run_phase(GAP_CIURA, 59, 0, 64, SET_CAPACITY, 1'b1, 1'b0, 1'b0);
    // Unused selector behaves as powers of two; slow receiver and a long hold.
    run_phase(GAP_UNUSED, 0, 59, 15, 0, 1'b1, 1'b1, 1'b0);
    // Powers of two with light idling on both sides and a drain mid-phase.
    run_phase(GAP_POW2, 9, 9, 55, $urandom_range(41, 63), 1'b1, 1'b0, 1'b1);
    run_phase(GAP_CIURA, 59, 0, 15, 0, 1'b1, 1'b0, 1'b0);
    run_phase(GAP_KNUTH, 0, 59, 15, 0, 1'b1, 1'b0, 1'b0);

    // Anything arriving now has no expectation and is flagged by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      report_mismatch("items never emitted", DATA_W'(sorted_q.size()), '0);
    end

    $display("Sorted %0d data sets from %0d elements, %0d items checked, all gap codes,",
             sets_closed, items_sent, results_seen);
    $display("with full-store sets, equal keys, extremes, idling mixes and a long output hold.");
    if (fail_count == 0) begin
      $display("shell_sort_engine_top_tb passed");
    end else begin
      $display("shell_sort_engine_top_tb failed");
    end
    $finish;
  end

endmodule

[shell_sort_engine_top.f]
rtl/core/sse_pkg.sv
rtl/core/shell_sort_engine_top.sv
test/shell_sort_engine_top_tb.sv
